// ----- rtl/trimmed_mean_adc_averager_core_assert.svh -----
// Assertion helpers for the checker
`ifndef TRIMMED_MEAN_ADC_AVERAGER_CORE_ASSERT_SVH
`define TRIMMED_MEAN_ADC_AVERAGER_CORE_ASSERT_SVH

// same-cycle implication
`define TMAA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMAA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tmaa_pkg.sv -----
`default_nettype none
package tmaa_pkg;

	localparam int CFG_BITS   = 7;
	localparam int CFG_RESET  = 16;
	localparam int MIN_BURST  = 7;
	localparam int TRIM_COUNT = 6;
	localparam int OUT_BITS   = 12;
	localparam int OUT_MAX    = 4095;

	typedef struct packed {
		logic load;
		logic xsum;
		logic trim;
		logic step;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic last;
		logic div_last;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/tmaa_sample_if.sv -----
`default_nettype none
interface tmaa_sample_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/tmaa_result_if.sv -----
`default_nettype none
interface tmaa_result_if;
	logic                           valid;
	logic                           ready;
	logic [tmaa_pkg::OUT_BITS-1:0]  trimmed_average;

	modport source (output valid, output trimmed_average, input ready);
	modport sink   (input valid, input trimmed_average, output ready);
endinterface
`default_nettype wire

// ----- rtl/tmaa_datapath.sv -----
`default_nettype none
module tmaa_datapath #(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_BURST   = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [tmaa_pkg::CFG_BITS-1:0] cfg_wr_data,
	input  wire logic [SAMPLE_BITS-1:0]        sample,
	input  wire tmaa_pkg::ctl_cmd_t            cmd,
	output tmaa_pkg::ctl_sts_t                 sts,
	output logic [tmaa_pkg::OUT_BITS-1:0]      trimmed_average
);
	import tmaa_pkg::*;

	localparam int PW  = $clog2(MAX_BURST + 1);
	localparam int CW  = (PW > CFG_BITS) ? PW : CFG_BITS;
	localparam int SW  = SAMPLE_BITS + PW;
	localparam int XW  = SAMPLE_BITS + 3;
	localparam int QW  = (SW > OUT_BITS) ? SW : OUT_BITS;
	localparam int DCW = $clog2(SW + 1);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = {SAMPLE_BITS{1'b1}};

	logic [CFG_BITS-1:0]    cfg_q;
	logic [PW-1:0]          pos_q;
	logic [SW-1:0]          sum_q;
	logic [SAMPLE_BITS-1:0] lo_q [3];
	logic [SAMPLE_BITS-1:0] hi_q [3];
	logic [SAMPLE_BITS-1:0] lo_n [3];
	logic [SAMPLE_BITS-1:0] hi_n [3];
	logic [PW-1:0]          divisor_q;
	logic [XW-1:0]          xsum_q;
	logic [SW-1:0]          quo_q;
	logic [PW-1:0]          rem_q;
	logic [DCW-1:0]         div_cnt_q;
	logic [OUT_BITS-1:0]    result_q;

	logic [CW-1:0]          cfg_ext;
	logic [PW-1:0]          count;
	logic [PW-1:0]          pos_inc;
	logic [PW:0]            trial;
	logic [PW:0]            diff;
	logic [QW-1:0]          quo_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_BITS'(CFG_RESET);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_comb begin
		cfg_ext = CW'(cfg_q);
		priority if (cfg_ext < CW'(MIN_BURST)) begin
			count = PW'(MIN_BURST);
		end else if (cfg_ext > CW'(MAX_BURST)) begin
			count = PW'(MAX_BURST);
		end else begin
			count = PW'(cfg_ext);
		end
		pos_inc      = pos_q + PW'(1);
		sts.last     = (pos_inc >= count);
		sts.div_last = (div_cnt_q == DCW'(1));
	end

	// sorted insertion, strict compares
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (sample < lo_q[2]) begin
			if (sample < lo_q[1]) begin
				lo_n[2] = lo_q[1];
				if (sample < lo_q[0]) begin
					lo_n[1] = lo_q[0];
					lo_n[0] = sample;
				end else begin
					lo_n[1] = sample;
				end
			end else begin
				lo_n[2] = sample;
			end
		end
		if (sample > hi_q[2]) begin
			if (sample > hi_q[1]) begin
				hi_n[2] = hi_q[1];
				if (sample > hi_q[0]) begin
					hi_n[1] = hi_q[0];
					hi_n[0] = sample;
				end else begin
					hi_n[1] = sample;
				end
			end else begin
				hi_n[2] = sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			lo_q  <= '{default: SAMPLE_TOP};
			hi_q  <= '{default: '0};
		end else if (cmd.finish) begin
			pos_q <= '0;
			sum_q <= '0;
			lo_q  <= '{default: SAMPLE_TOP};
			hi_q  <= '{default: '0};
		end else if (cmd.load) begin
			pos_q <= pos_inc;
			sum_q <= sum_q + SW'(sample);
			lo_q  <= lo_n;
			hi_q  <= hi_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.trim) begin
			div_cnt_q <= DCW'(SW);
		end else if (cmd.step) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// restoring divider, one quotient bit a cycle
	always_comb begin
		trial   = {rem_q, quo_q[SW-1]};
		diff    = trial - {1'b0, divisor_q};
		quo_ext = QW'(quo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load && sts.last) begin
			divisor_q <= count - PW'(TRIM_COUNT);
		end
		if (cmd.xsum) begin
			xsum_q <= XW'(lo_q[0]) + XW'(lo_q[1]) + XW'(lo_q[2])
			        + XW'(hi_q[0]) + XW'(hi_q[1]) + XW'(hi_q[2]);
		end
		if (cmd.trim) begin
			quo_q <= (sum_q >= SW'(xsum_q)) ? (sum_q - SW'(xsum_q)) : '0;
			rem_q <= '0;
		end else if (cmd.step) begin
			if (!diff[PW]) begin
				rem_q <= diff[PW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= trial[PW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			result_q <= (quo_ext > QW'(OUT_MAX)) ? OUT_BITS'(OUT_MAX)
			                                     : quo_ext[OUT_BITS-1:0];
		end
	end

	assign trimmed_average = result_q;

endmodule
`default_nettype wire

// ----- rtl/tmaa_ctrl.sv -----
`default_nettype none
module tmaa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire tmaa_pkg::ctl_sts_t sts,
	output tmaa_pkg::ctl_cmd_t      cmd
);
	import tmaa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_XSUM,
		S_TRIM,
		S_DIV,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		accept     = in_valid && in_ready;
		out_free   = !out_valid_q || out_ready;
		cmd.load   = accept;
		cmd.xsum   = (state_q == S_XSUM);
		cmd.trim   = (state_q == S_TRIM);
		cmd.step   = (state_q == S_DIV);
		cmd.finish = (state_q == S_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && sts.last) begin
						state_q <= S_XSUM;
					end
				end
				S_XSUM: begin
					state_q <= S_TRIM;
				end
				S_TRIM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/trimmed_mean_adc_averager_core.sv -----
// Samples within a burst: one transaction per cycle, state updated at the accepting edge.
// Last sample of a burst: the controller then passes XSUM, TRIM, the bit-serial restoring
// divide (DIV) and HOLD before the result is valid; no samples are taken meanwhile.
// Input stalls while a finished result cannot enter a still occupied output register.
// Asynchronous active-low reset: count register to 16, burst state cleared, output empty.
`default_nettype none
module trimmed_mean_adc_averager_core #(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_BURST   = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [tmaa_pkg::CFG_BITS-1:0] cfg_wr_data,
	tmaa_sample_if.sink                        adc,
	tmaa_result_if.source                      avg
);
	import tmaa_pkg::*;

	ctl_cmd_t               cmd;
	ctl_sts_t               sts;
	logic [SAMPLE_BITS-1:0] sample;

	assign sample = adc.sample;

	tmaa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adc.valid),
		.in_ready  (adc.ready),
		.out_valid (avg.valid),
		.out_ready (avg.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tmaa_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_BURST   (MAX_BURST)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.sample          (sample),
		.cmd             (cmd),
		.sts             (sts),
		.trimmed_average (avg.trimmed_average)
	);

endmodule
`default_nettype wire

// ----- rtl/tmaa_checker.sv -----
`default_nettype none
`include "trimmed_mean_adc_averager_core_assert.svh"
module tmaa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [tmaa_pkg::OUT_BITS-1:0] out_data
);
	import tmaa_pkg::*;

	// input closes only after taking a sample
	`TMAA_ASSERT_IMP(a_ready_falls_on_take, clk, arst_n, $fell(in_ready), $past(in_valid), "input closed without a transaction")

	// a result appears as the input reopens after the divide
	`TMAA_ASSERT_IMP(a_result_reopens, clk, arst_n, $rose(out_valid), in_ready && !$past(in_ready), "result raised outside burst end")

	`TMAA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind trimmed_mean_adc_averager_core tmaa_checker u_tmaa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (adc.valid),
	.in_ready  (adc.ready),
	.out_valid (avg.valid),
	.out_ready (avg.ready),
	.out_data  (avg.trimmed_average)
);
`default_nettype wire
